[rtl/lrufbp_pkg.sv]
// ============================================================================
// lrufbp_pkg
// Shared types and codes for the frame buffer pool allocator.
// ============================================================================
package lrufbp_pkg;

    localparam int AGE_W    = 32;
    localparam int COUNT_W  = 6;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 3;

    // operation codes
    localparam logic OP_GET     = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_FREE_GRANTED  = 3'd0,
        ST_OLDEST_REUSED = 3'd1,
        ST_NONE          = 3'd2,
        ST_RELEASED      = 3'd3,
        ST_UNMATCHED     = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REL,
        S_SCAN,
        S_LAST,
        S_GRANT,
        S_FIN
    } t_state;

    // control from the sequencer to the entry store
    typedef struct packed {
        logic rd_en;
        logic release_wr;
        logic grant_wr;
    } t_store_ctl;

endpackage

[rtl/lrufbp_if.sv]
// ============================================================================
// lrufbp interfaces
// Request, response and configuration channels of the buffer pool.
// ============================================================================
interface lrufbp_req_if;
    import lrufbp_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [INDEX_W-1:0] buffer_index;

    modport source (output valid, operation, buffer_index, input ready);
    modport sink   (input valid, operation, buffer_index, output ready);
endinterface

interface lrufbp_rsp_if;
    import lrufbp_pkg::*;
    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  granted_index;
    logic [STATUS_W-1:0] status;

    modport source (output valid, granted_index, status, input ready);
    modport sink   (input valid, granted_index, status, output ready);
endinterface

interface lrufbp_cfg_if;
    import lrufbp_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/lru_frame_buffer_pool.sv]
// ============================================================================
// lru_frame_buffer_pool
// Least-recently-released frame buffer allocator with a sequential scan.
// ============================================================================
// Each request holds the block from its acceptance until the next request can
// be taken. A release passes through the release and finish states: it stamps
// the entry with the incremented age counter and frees it, or is answered as
// unmatched when the index is outside the active pool. A get walks the active
// entries one per cycle through the single read port of the age memory and a
// shared compare unit, then passes through the last, grant and finish states.
// A get on an empty pool goes straight to the finish state. The block takes
// one request at a time. It accepts the next request once the previous result
// sits in the output register, so a stalled response adds its stall cycles.
// Configuration writes are taken only while the block is idle, and they win
// over a request offered in the same cycle. active_count above BUFFERS acts as
// BUFFERS. No clearing pass after reset.
// ============================================================================
module lru_frame_buffer_pool
    import lrufbp_pkg::*;
#(
    parameter int BUFFERS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrufbp_cfg_if.sink    i_cfg,
    lrufbp_req_if.sink    i_req,
    lrufbp_rsp_if.source  o_rsp
);

    localparam int IDX_W = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
    localparam int CNT_W = $clog2(BUFFERS + 1);

    t_state              r_state;
    t_state              n_state;
    logic [COUNT_W-1:0]  r_active;
    logic [AGE_W-1:0]    r_age_ctr;
    logic [INDEX_W-1:0]  r_idx;
    logic [CNT_W-1:0]    r_addr;
    logic [INDEX_W-1:0]  r_gr;
    t_status             r_st;
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_gr;
    t_status             r_out_st;

    logic [CNT_W-1:0]    eff;
    logic                req_fire;
    logic                out_free;
    logic                idx_in_range;
    logic                scan_last;
    t_store_ctl          store_ctl;
    logic                cmp_start;
    logic [IDX_W-1:0]    wr_addr;
    logic                st_step;
    logic [IDX_W-1:0]    st_idx;
    logic [AGE_W-1:0]    st_age;
    logic                st_free;
    logic                have_free;
    logic [IDX_W-1:0]    best_free;
    logic [IDX_W-1:0]    best_any;

    // effective pool size
    assign eff = ({26'b0, r_active} > 32'(BUFFERS)) ? CNT_W'(BUFFERS) : CNT_W'(r_active);

    assign req_fire     = i_req.valid && i_req.ready;
    assign out_free     = !r_out_valid || o_rsp.ready;
    assign idx_in_range = ({27'b0, r_idx} < 32'(eff));
    assign scan_last    = (CNT_W'(r_addr + 1'b1) == eff);

    // configuration register
    assign i_cfg.ready = (r_state == S_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= COUNT_W'(18);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_active <= i_cfg.data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    if (i_req.operation == OP_RELEASE) begin
                        n_state = S_REL;
                    end else if (eff == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_REL:   n_state = S_FIN;
            S_SCAN:  n_state = scan_last ? S_LAST : S_SCAN;
            S_LAST:  n_state = S_GRANT;
            S_GRANT: n_state = S_FIN;
            S_FIN:   n_state = out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_req.ready          = 1'b0;
        store_ctl.rd_en      = 1'b0;
        store_ctl.release_wr = 1'b0;
        store_ctl.grant_wr   = 1'b0;
        cmp_start            = 1'b0;
        wr_addr              = IDX_W'(r_idx);
        case (r_state)
            S_IDLE: begin
                // a pending configuration write goes first
                i_req.ready = !i_cfg.valid;
                cmp_start   = 1'b1;
            end
            S_REL: begin
                store_ctl.release_wr = idx_in_range;
            end
            S_SCAN: begin
                store_ctl.rd_en = 1'b1;
            end
            S_GRANT: begin
                store_ctl.grant_wr = 1'b1;
                wr_addr            = have_free ? best_free : best_any;
            end
            default: begin
            end
        endcase
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_age_ctr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_REL && idx_in_range) begin
                r_age_ctr <= r_age_ctr + 1'b1;
            end
        end
    end

    // request capture, scan address and pending result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx  <= i_req.buffer_index;
                r_addr <= '0;
                r_gr   <= '0;
                r_st   <= ST_NONE;
            end
            S_REL: begin
                r_st <= idx_in_range ? ST_RELEASED : ST_UNMATCHED;
            end
            S_SCAN: begin
                r_addr <= CNT_W'(r_addr + 1'b1);
            end
            S_GRANT: begin
                r_gr <= INDEX_W'(have_free ? best_free : best_any);
                r_st <= have_free ? ST_FREE_GRANTED : ST_OLDEST_REUSED;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_gr <= r_gr;
            r_out_st <= r_st;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.granted_index = r_out_gr;
    assign o_rsp.status        = r_out_st;

    lrufbp_store #(
        .BUFFERS (BUFFERS),
        .IDX_W   (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .i_wr_addr (wr_addr),
        .i_wr_age  (AGE_W'(r_age_ctr + 1'b1)),
        .o_step    (st_step),
        .o_idx     (st_idx),
        .o_age     (st_age),
        .o_free    (st_free)
    );

    lrufbp_cmp #(
        .IDX_W (IDX_W)
    ) u_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (cmp_start),
        .i_step      (st_step),
        .i_idx       (st_idx),
        .i_age       (st_age),
        .i_free      (st_free),
        .o_have_free (have_free),
        .o_best_free (best_free),
        .o_best_any  (best_any)
    );

    // the age counter moves only on a matched release
    a_age_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_REL && idx_in_range) |=> $stable(r_age_ctr))
        else $error("age counter changed outside a release");

    // the scan never addresses beyond the active pool
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({{(32-CNT_W){1'b0}}, r_addr} < 32'(eff)))
        else $error("scan address outside active pool");

    // only grants carry a nonzero index
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_st == ST_NONE || r_out_st == ST_RELEASED
                         || r_out_st == ST_UNMATCHED)) |-> (r_out_gr == '0))
        else $error("non-grant result carries an index");

endmodule

[rtl/lrufbp_store.sv]
// ============================================================================
// lrufbp_store
// Entry store: age stamp memory with per-entry valid bits, in-use flags,
// and one registered read port that feeds the scan.
// ============================================================================
module lrufbp_store
    import lrufbp_pkg::*;
#(
    parameter int BUFFERS = 32,
    parameter int IDX_W   = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_ctl       i_ctl,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [AGE_W-1:0] i_wr_age,
    output logic             o_step,
    output logic [IDX_W-1:0] o_idx,
    output logic [AGE_W-1:0] o_age,
    output logic             o_free
);

    logic [AGE_W-1:0]   r_mem [BUFFERS];
    logic [BUFFERS-1:0] r_written;
    logic [BUFFERS-1:0] r_used;
    logic [AGE_W-1:0]   r_rd_data;
    logic               r_rd_ok;
    logic               r_step;
    logic [IDX_W-1:0]   r_idx;
    logic               r_free;

    // age memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.release_wr) begin
            r_mem[i_wr_addr] <= i_wr_age;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_idx     <= i_rd_addr;
    end

    // written and in-use flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_used    <= '0;
        end else if (i_ctl.release_wr) begin
            r_written[i_wr_addr] <= 1'b1;
            r_used[i_wr_addr]    <= 1'b0;
        end else if (i_ctl.grant_wr) begin
            r_used[i_wr_addr] <= 1'b1;
        end
    end

    // flag side of the read port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 1'b0;
            r_rd_ok <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            r_step  <= i_ctl.rd_en;
            r_rd_ok <= r_written[i_rd_addr];
            r_free  <= !r_used[i_rd_addr];
        end
    end

    // an entry never stamped reads as age zero
    assign o_age  = r_rd_ok ? r_rd_data : '0;
    assign o_step = r_step;
    assign o_idx  = r_idx;
    assign o_free = r_free;

endmodule

[rtl/lrufbp_cmp.sv]
// ============================================================================
// lrufbp_cmp
// Shared compare unit: tracks the oldest free entry and the oldest entry
// overall, one entry per step, lowest index winning ties.
// ============================================================================
module lrufbp_cmp
    import lrufbp_pkg::*;
#(
    parameter int IDX_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_step,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [AGE_W-1:0] i_age,
    input  logic             i_free,
    output logic             o_have_free,
    output logic [IDX_W-1:0] o_best_free,
    output logic [IDX_W-1:0] o_best_any
);

    logic             r_first;
    logic             r_have_free;
    logic [IDX_W-1:0] r_best_free;
    logic [AGE_W-1:0] r_free_age;
    logic [IDX_W-1:0] r_best_any;
    logic [AGE_W-1:0] r_any_age;
    logic             take_free;
    logic             take_any;

    // strict less-than keeps the earlier (lower) index on ties
    assign take_free = i_step && i_free && (!r_have_free || (r_free_age > i_age));
    assign take_any  = i_step && (r_first || (r_any_age > i_age));

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_have_free <= 1'b0;
        end else if (i_start) begin
            r_first     <= 1'b1;
            r_have_free <= 1'b0;
        end else begin
            if (i_step) begin
                r_first <= 1'b0;
            end
            if (take_free) begin
                r_have_free <= 1'b1;
            end
        end
    end

    // best candidates
    always_ff @(posedge i_clk) begin
        if (take_free) begin
            r_best_free <= i_idx;
            r_free_age  <= i_age;
        end
        if (take_any) begin
            r_best_any <= i_idx;
            r_any_age  <= i_age;
        end
    end

    assign o_have_free = r_have_free;
    assign o_best_free = r_best_free;
    assign o_best_any  = r_best_any;

    // a free candidate, once found, is never lost within a scan
    a_free_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_have_free && !i_start) |=> r_have_free)
        else $error("free candidate dropped during scan");

    // first step always seeds the overall candidate
    a_first_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first && i_step && !i_start) |=> (!r_first && r_best_any == $past(i_idx)))
        else $error("overall candidate not seeded by first entry");

    // a free candidate only appears from a free entry
    a_free_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_have_free && !i_start && !(i_step && i_free)) |=> !r_have_free)
        else $error("free candidate without a free entry");

endmodule
